// ===== sv/prh_pkg.sv =====
// ----------------------------------------------------------------------------
// prh_pkg
// Shared types, request and status codes and the base/prime table of the
// prefix rolling hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prh_pkg;

  localparam int WORD_W    = 32;
  localparam int SEL_W     = 3;
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 11;
  localparam int STAT_W    = 2;
  localparam int STEP_W    = $clog2(WORD_W);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_RED,
    MM_MUL,
    MM_ADD,
    MM_FIN
  } mm_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_READ2,
    S_RED,
    S_NEG,
    S_MAC,
    S_DONE
  } seq_state_t;

  // Operands of one modular multiply-accumulate: (a * b + c) mod m.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t m;
  } mm_op_t;

  // Selectors above the last pair saturate to the last pair.
  function automatic word_t pair_base(input logic [SEL_W-1:0] sel);
    case (sel)
      3'd0:    return 32'd128;
      3'd1:    return 32'd243;
      3'd2:    return 32'd125;
      3'd3:    return 32'd1340132568;
      3'd4:    return 32'd1025585316;
      default: return 32'd216;
    endcase
  endfunction

  function automatic word_t pair_prime(input logic [SEL_W-1:0] sel);
    case (sel)
      3'd0:    return 32'd2000000011;
      3'd1:    return 32'd2000000033;
      3'd2:    return 32'd2000000063;
      3'd3:    return 32'd2147467057;
      3'd4:    return 32'd2147483353;
      default: return 32'd3000001811;
    endcase
  endfunction

endpackage

// ===== sv/prh_channels.sv =====
// ----------------------------------------------------------------------------
// prh_channels
// Valid/ready channels of the prefix rolling hash: request, result and
// configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prh_in_if;
  import prh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  word_t                value;
  logic [IDX_W-1:0]     start_index;
  logic [IDX_W-1:0]     length;

  modport source (output valid, req_type, value, start_index, length, input ready);
  modport sink   (input valid, req_type, value, start_index, length, output ready);
endinterface

interface prh_out_if;
  import prh_pkg::*;
  logic                 valid;
  logic                 ready;
  word_t                hash_value;
  logic [STAT_W-1:0]    status;

  modport source (output valid, hash_value, status, input ready);
  modport sink   (input valid, hash_value, status, output ready);
endinterface

interface prh_cfg_if;
  import prh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SEL_W-1:0]     table_select;

  modport source (output valid, table_select, input ready);
  modport sink   (input valid, table_select, output ready);
endinterface

// ===== sv/prh_modmac.sv =====
// ----------------------------------------------------------------------------
// prh_modmac
// Bit-serial modular multiply-accumulate: (a * b + c) mod m, one multiplier
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prh_modmac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  prh_pkg::mm_op_t              op,
  output logic                         done,
  output logic [prh_pkg::WORD_W-1:0]   result
);
  import prh_pkg::*;

  mm_state_t         state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  word_t             a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, m_r, m_nxt, acc_r, acc_nxt;
  logic [WORD_W:0]   a_sub, c_sub, sum_add, sum_sub;
  logic [WORD_W+1:0] dbl, dbl_m1, dbl_m2;

  always_comb begin
    a_sub   = {1'b0, a_r} - {1'b0, m_r};
    c_sub   = {1'b0, c_r} - {1'b0, m_r};
    dbl     = {1'b0, acc_r, 1'b0} + {2'b00, (b_r[WORD_W-1] ? a_r : {WORD_W{1'b0}})};
    dbl_m1  = dbl - {2'b00, m_r};
    dbl_m2  = dbl - {1'b0, m_r, 1'b0};
    sum_add = {1'b0, acc_r} + {1'b0, c_r};
    sum_sub = sum_add - {1'b0, m_r};

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    done      = 1'b0;

    case (state_r)
      MM_IDLE: begin
        if (start) begin
          a_nxt     = op.a;
          b_nxt     = op.b;
          c_nxt     = op.c;
          m_nxt     = op.m;
          cnt_nxt   = STEP_W'(1);
          state_nxt = MM_RED;
        end
      end
      MM_RED: begin
        // Two conditional subtractions bring a and c below m.
        a_nxt = a_sub[WORD_W] ? a_r : a_sub[WORD_W-1:0];
        c_nxt = c_sub[WORD_W] ? c_r : c_sub[WORD_W-1:0];
        if (cnt_r == '0) begin
          acc_nxt   = '0;
          cnt_nxt   = STEP_W'(WORD_W - 1);
          state_nxt = MM_MUL;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      MM_MUL: begin
        if (!dbl_m2[WORD_W+1]) begin
          acc_nxt = dbl_m2[WORD_W-1:0];
        end else if (!dbl_m1[WORD_W+1]) begin
          acc_nxt = dbl_m1[WORD_W-1:0];
        end else begin
          acc_nxt = dbl[WORD_W-1:0];
        end
        b_nxt = {b_r[WORD_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = MM_ADD;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      MM_ADD: begin
        acc_nxt   = sum_sub[WORD_W] ? sum_add[WORD_W-1:0] : sum_sub[WORD_W-1:0];
        state_nxt = MM_FIN;
      end
      MM_FIN: begin
        done      = 1'b1;
        state_nxt = MM_IDLE;
      end
      default: begin
        state_nxt = MM_IDLE;
      end
    endcase
  end

  assign result = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// ===== sv/prefix_rolling_hash.sv =====
// ----------------------------------------------------------------------------
// prefix_rolling_hash
// Polynomial rolling hash over an appended sequence with substring queries.
//
// Requests arrive on in_chan: clear, append an element, or query the hash of
// a substring. Each request yields exactly one result on out_chan with the
// hash and a status. cfg_chan writes the base/prime pair selector; write it
// only while no request is in flight.
// One request is processed at a time. A clear, an empty query or a
// rejected request goes straight to the result register; an append or a
// non-empty query passes through the 32-step bit-serial modular multiplier,
// which handles one multiplier bit a cycle.
// The next request is accepted in the cycle after the result is registered,
// even while that result still waits on out_chan.
// If the receiver stalls, the finished result holds in the output register
// and the following result waits in its own register until it is taken.
// Reset empties the sequence and selects pair 0. The stores need no
// clearing pass: entry zero reads as its fixed value and later entries are
// read only after they are written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_rolling_hash #(
  parameter int MAX_LEN = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  prh_in_if.sink    in_chan,
  prh_out_if.source out_chan,
  prh_cfg_if.sink   cfg_chan
);
  import prh_pkg::*;

  localparam int DEPTH = MAX_LEN + 1;
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int SUMW  = IDX_W + 1;
  localparam int CMPW  = (CW > SUMW) ? CW : SUMW;

  seq_state_t        state_r, state_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  word_t             val_r, val_nxt;
  logic [IDX_W-1:0]  s_r, s_nxt, l_r, l_nxt;
  word_t             base_r, base_nxt, prime_r, prime_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  word_t             res_hash_r, res_hash_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  word_t             pa_r, pa_nxt, pc_r, pc_nxt, pw_r, pw_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             out_hash_r, out_hash_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  word_t             ph_mem [DEPTH];
  word_t             pw_mem [DEPTH];
  logic [CW-1:0]     ph_raddr, pw_raddr, waddr;
  logic              we;
  word_t             ph_rdata_r, pw_rdata_r, ph_rd, pw_rd;
  logic              ph_zero_r, pw_zero_r;

  logic [SUMW-1:0]   in_end, q_end;
  logic [WORD_W:0]   pw_diff;

  mm_op_t            h_op, p_op;
  logic              h_start, p_start, h_done, p_done;
  word_t             h_res, p_res;

  prh_modmac u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (h_start),
    .op     (h_op),
    .done   (h_done),
    .result (h_res)
  );

  prh_modmac u_pow (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (p_start),
    .op     (p_op),
    .done   (p_done),
    .result (p_res)
  );

  assign ph_rd = ph_zero_r ? '0 : ph_rdata_r;
  assign pw_rd = pw_zero_r ? WORD_W'(1) : pw_rdata_r;

  assign in_chan.ready       = (state_r == S_IDLE);
  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = out_hash_r;
  assign out_chan.status     = out_stat_r;

  always_comb begin
    sel_nxt = (cfg_chan.valid) ? cfg_chan.table_select : sel_r;

    in_end  = SUMW'(in_chan.start_index) + SUMW'(in_chan.length);
    q_end   = SUMW'(s_r) + SUMW'(l_r);
    pw_diff = {1'b0, pw_r} - {1'b0, prime_r};

    state_nxt    = state_r;
    req_nxt      = req_r;
    val_nxt      = val_r;
    s_nxt        = s_r;
    l_nxt        = l_r;
    base_nxt     = base_r;
    prime_nxt    = prime_r;
    count_nxt    = count_r;
    res_hash_nxt = res_hash_r;
    res_stat_nxt = res_stat_r;
    pa_nxt       = pa_r;
    pc_nxt       = pc_r;
    pw_nxt       = pw_r;
    out_hash_nxt = out_hash_r;
    out_stat_nxt = out_stat_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    ph_raddr = count_r;
    pw_raddr = count_r;
    waddr    = count_r + CW'(1);
    we       = 1'b0;
    h_start  = 1'b0;
    p_start  = 1'b0;
    h_op     = '{a: ph_rd, b: base_r, c: val_r, m: prime_r};
    p_op     = '{a: pw_rd, b: base_r, c: '0, m: prime_r};

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          req_nxt      = in_chan.req_type;
          val_nxt      = in_chan.value;
          s_nxt        = in_chan.start_index;
          l_nxt        = in_chan.length;
          base_nxt     = pair_base(sel_r);
          prime_nxt    = pair_prime(sel_r);
          res_hash_nxt = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = S_DONE;
          case (in_chan.req_type)
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            REQ_APPEND: begin
              if (count_r == CW'(MAX_LEN)) begin
                res_stat_nxt = STAT_FULL;
              end else begin
                state_nxt = S_READ;
              end
            end
            REQ_QUERY: begin
              if (in_chan.length != '0) begin
                if (CMPW'(in_end) > CMPW'(count_r)) begin
                  res_stat_nxt = STAT_RANGE;
                end else begin
                  state_nxt = S_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (req_r != REQ_APPEND) begin
          ph_raddr = CW'(s_r);
          pw_raddr = CW'(l_r);
        end
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (req_r == REQ_APPEND) begin
          h_start   = 1'b1;
          p_start   = 1'b1;
          state_nxt = S_MAC;
        end else begin
          pa_nxt    = ph_rd;
          pw_nxt    = pw_rd;
          ph_raddr  = CW'(q_end);
          state_nxt = S_READ2;
        end
      end
      S_READ2: begin
        pc_nxt    = ph_rd;
        pw_nxt    = pw_diff[WORD_W] ? pw_r : pw_diff[WORD_W-1:0];
        state_nxt = S_RED;
      end
      S_RED: begin
        pw_nxt    = pw_diff[WORD_W] ? pw_r : pw_diff[WORD_W-1:0];
        state_nxt = S_NEG;
      end
      S_NEG: begin
        h_op.a    = pa_r;
        h_op.b    = prime_r - pw_r;
        h_op.c    = pc_r;
        h_start   = 1'b1;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        if (h_done && (p_done || req_r != REQ_APPEND)) begin
          res_hash_nxt = h_res;
          if (req_r == REQ_APPEND) begin
            we        = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = res_hash_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    val_r      <= val_nxt;
    s_r        <= s_nxt;
    l_r        <= l_nxt;
    base_r     <= base_nxt;
    prime_r    <= prime_nxt;
    res_hash_r <= res_hash_nxt;
    res_stat_r <= res_stat_nxt;
    pa_r       <= pa_nxt;
    pc_r       <= pc_nxt;
    pw_r       <= pw_nxt;
    out_hash_r <= out_hash_nxt;
    out_stat_r <= out_stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ph_mem[waddr] <= h_res;
      pw_mem[waddr] <= p_res;
    end
    ph_rdata_r <= ph_mem[ph_raddr];
    pw_rdata_r <= pw_mem[pw_raddr];
    ph_zero_r  <= (ph_raddr == '0);
    pw_zero_r  <= (pw_raddr == '0);
  end

endmodule

// ===== sv/prh_checker.sv =====
// ----------------------------------------------------------------------------
// prh_checker
// Port-level checks of the prefix rolling hash, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prh_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [prh_pkg::WORD_W-1:0]  out_hash_value,
  input logic [prh_pkg::STAT_W-1:0]  out_status
);
  import prh_pkg::*;

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A result never appears in the cycle right after a request is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early after a request");

  // A rejected request carries a zero hash.
  a_error_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_hash_value == '0)
    else $error("nonzero hash with an error status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind prefix_rolling_hash prh_checker u_prh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_hash_value (out_chan.hash_value),
  .out_status     (out_chan.status)
);
